// ===== design/rse_pkg.sv =====
package rse_pkg;

	// default sizes
	localparam int MAX_ELEMENTS_DEF  = 1024;
	localparam int ELEMENT_WIDTH_DEF = 32;

	// request command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PICK = 1'b1;

	// reset value of the pass count register
	localparam logic [7:0] PASS_COUNT_RST = 8'd1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] element_value;
		logic               load_last;
		logic               coin;
	} rse_in_t;

	typedef struct packed {
		logic signed [31:0] picked_value;
		logic               pass_end;
		logic               shuffle_end;
	} rse_out_t;

	// controller to datapath
	typedef struct packed {
		logic cfg_we;
		logic ld;
		logic pk;
		logic fin;
	} rse_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_array;
	} rse_status_t;

endpackage

// ===== design/riffle_shuffle_engine.sv =====
// riffle shuffle engine: a load request is written at acceptance; a pick request does a
// registered read of the current bank, then the work-bank write and result load.
// the controller holds the request port until the work write is done, so a new pick
// is not accepted before the last one has finished.
// pass end swaps the two banks instead of copying; a stalled result holds the next pick.
// arst_n clears counters, pass state and handshake; bank contents are undefined.
module riffle_shuffle_engine #(
	parameter int MAX_ELEMENTS  = rse_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = rse_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rse_pkg::rse_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rse_pkg::rse_out_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	rse_pkg::rse_cmd_t    cmd;
	rse_pkg::rse_status_t st;

	rse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rse_dpath #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	// a finished pick always shows up as a result in the next cycle
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> rsp_valid)
		else $error("pick finished without a result");

	// the request port stays closed while a pick read is in flight
	a_pick_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pk |=> req_stall)
		else $error("request accepted during a pick");

	// a shuffle only ends on the last pick of a pass
	a_shuf_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.shuffle_end || rsp.pass_end))
		else $error("shuffle end without pass end");
`endif

endmodule

// ===== design/rse_ctrl.sv =====
module rse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_cmd,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rse_pkg::rse_status_t st,
	output rse_pkg::rse_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RESP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   req_take;
	logic   out_free;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.cfg_we = cfg_valid;
		cmd.ld     = req_take && (req_cmd == rse_pkg::CMD_LOAD);
		cmd.pk     = req_take && (req_cmd == rse_pkg::CMD_PICK) && st.has_array;
		cmd.fin    = (state_q == ST_RESP) && out_free;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.pk) begin
					state_nx = ST_RESP;
				end
			end
			ST_RESP: begin
				if (cmd.fin) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/rse_dpath.sv =====
module rse_dpath #(
	parameter int MAX_ELEMENTS  = rse_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = rse_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rse_pkg::rse_in_t     req,
	input  logic [7:0]           cfg_data,
	input  rse_pkg::rse_cmd_t    cmd,
	output rse_pkg::rse_status_t st,
	output rse_pkg::rse_out_t    rsp
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int EW = ELEMENT_WIDTH;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	// two banks, sel_q names the one holding the current order
	logic [EW-1:0] bank_a [MAX_ELEMENTS];
	logic [EW-1:0] bank_b [MAX_ELEMENTS];

	logic [CW-1:0] count_q;
	logic [CW-1:0] load_pos_q;
	logic [CW-1:0] out_pos_q;
	logic [CW-1:0] first_q;
	logic [CW-1:0] second_q;
	logic [7:0]    passes_q;
	logic [7:0]    pass_count_q;
	logic          sel_q;

	logic [EW-1:0] rd_a_s1;
	logic [EW-1:0] rd_b_s1;
	logic          rd_sel_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          pass_end_s1;
	logic          shuffle_end_s1;
	rse_pkg::rse_out_t rsp_q;

	logic [CW-1:0] half;
	logic          take_first;
	logic [CW-1:0] src;
	logic [CW-1:0] out_pos_nx;
	logic          pass_last;
	logic [7:0]    passes_nx;
	logic          shuf_last;
	logic          ld_ok;
	logic          ld_both;
	logic [CW-1:0] load_pos_inc;
	logic [EW+31:0] ld_wide;
	logic [EW-1:0] ld_val;
	logic [EW-1:0] rd_data;
	logic [EW+31:0] rd_wide;
	logic          we_a;
	logic          we_b;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	// pick source
	assign half       = count_q >> 1;
	assign take_first = (first_q < half) && ((second_q >= half) || !req.coin);
	assign src        = take_first ? first_q : (half + second_q);
	assign out_pos_nx = out_pos_q + ONE_C;
	assign pass_last  = (out_pos_nx >= count_q);
	assign passes_nx  = passes_q + 8'd1;
	assign shuf_last  = (passes_nx >= pass_count_q);

	// load path
	assign ld_ok        = (load_pos_q < MAX_C);
	assign ld_both      = (load_pos_q >= count_q);
	assign load_pos_inc = ld_ok ? (load_pos_q + ONE_C) : load_pos_q;
	assign ld_wide      = {{EW{1'b0}}, req.element_value};
	assign ld_val       = ld_wide[EW-1:0];

	// read data of the pick in flight
	assign rd_data = rd_sel_s1 ? rd_b_s1 : rd_a_s1;
	assign rd_wide = {32'd0, rd_data};

	// bank write ports, loads and work writes never share a cycle
	assign we_a  = (cmd.ld && ld_ok && (!sel_q || ld_both)) || (cmd.fin && rd_sel_s1);
	assign we_b  = (cmd.ld && ld_ok && (sel_q || ld_both)) || (cmd.fin && !rd_sel_s1);
	assign waddr = cmd.fin ? wr_addr_s1 : load_pos_q[AW-1:0];
	assign wdata = cmd.fin ? rd_data : ld_val;

	// memories
	always_ff @(posedge clk) begin
		if (we_a) begin
			bank_a[waddr] <= wdata;
		end
		if (cmd.pk) begin
			rd_a_s1 <= bank_a[src[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			bank_b[waddr] <= wdata;
		end
		if (cmd.pk) begin
			rd_b_s1 <= bank_b[src[AW-1:0]];
		end
	end

	// pick payload staging and result register
	always_ff @(posedge clk) begin
		if (cmd.pk) begin
			rd_sel_s1      <= sel_q;
			wr_addr_s1     <= out_pos_q[AW-1:0];
			pass_end_s1    <= pass_last;
			shuffle_end_s1 <= pass_last && shuf_last;
		end
		if (cmd.fin) begin
			rsp_q.picked_value <= $signed(rd_wide[31:0]);
			rsp_q.pass_end     <= pass_end_s1;
			rsp_q.shuffle_end  <= shuffle_end_s1;
		end
	end

	// counters and pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			load_pos_q   <= '0;
			out_pos_q    <= '0;
			first_q      <= '0;
			second_q     <= '0;
			passes_q     <= '0;
			pass_count_q <= rse_pkg::PASS_COUNT_RST;
			sel_q        <= 1'b0;
		end else begin
			if (cmd.cfg_we) begin
				pass_count_q <= cfg_data;
			end
			if (cmd.ld) begin
				if (req.load_last) begin
					count_q    <= load_pos_inc;
					load_pos_q <= '0;
					out_pos_q  <= '0;
					first_q    <= '0;
					second_q   <= '0;
					passes_q   <= '0;
				end else begin
					load_pos_q <= load_pos_inc;
				end
			end
			if (cmd.pk) begin
				if (pass_last) begin
					out_pos_q <= '0;
					first_q   <= '0;
					second_q  <= '0;
					sel_q     <= !sel_q;
					passes_q  <= shuf_last ? 8'd0 : passes_nx;
				end else begin
					out_pos_q <= out_pos_nx;
					if (take_first) begin
						first_q <= first_q + ONE_C;
					end else begin
						second_q <= second_q + ONE_C;
					end
				end
			end
		end
	end

	assign st.has_array = (count_q != '0);
	assign rsp          = rsp_q;

endmodule

// ===== dv/rse_checker.sv =====
`timescale 1ns / 100ps

module rse_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  rse_pkg::rse_in_t  req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  rse_pkg::rse_out_t rsp,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [7:0]        cfg_data,
	output int                fail_count,
	output int                pending,
	output int                results_seen
);

	localparam int DEPTH = rse_pkg::MAX_ELEMENTS_DEF;

	// shadow copy of the engine state
	logic [31:0] cur_mem [DEPTH];
	logic [31:0] wrk_mem [DEPTH];
	logic [10:0] elem_count;
	logic [10:0] load_pos;
	logic [10:0] out_pos;
	logic [10:0] first_taken;
	logic [10:0] second_taken;
	logic [7:0]  passes_done;
	logic [7:0]  pass_limit;

	// picks accepted whose result has not come back yet
	rse_pkg::rse_out_t picks_due [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_pass();
		out_pos      = '0;
		first_taken  = '0;
		second_taken = '0;
		passes_done  = '0;
	endtask

	// load request: write in order, last mark fixes the length
	task automatic store_element(input logic [31:0] value, input logic last);
		if (load_pos < DEPTH) begin
			cur_mem[load_pos[9:0]] = value;
			load_pos++;
		end
		if (last) begin
			elem_count = load_pos;
			load_pos   = '0;
			clear_pass();
		end
	endtask

	// pick request: choose the half, emit the element, swap order at pass end
	task automatic riffle_pick(input logic coin);
		logic [10:0]       half;
		logic [10:0]       src;
		rse_pkg::rse_out_t r;
		half = elem_count >> 1;
		if (first_taken < half && (second_taken >= half || coin == 1'b0)) begin
			src = first_taken;
			first_taken++;
		end else begin
			src = half + second_taken;
			second_taken++;
		end
		r.picked_value = (src < DEPTH) ? cur_mem[src[9:0]] : '0;
		r.pass_end     = 1'b0;
		r.shuffle_end  = 1'b0;
		if (out_pos < DEPTH)
			wrk_mem[out_pos[9:0]] = r.picked_value;
		out_pos++;
		if (out_pos >= elem_count) begin
			for (int i = 0; i < elem_count; i++)
				cur_mem[i] = wrk_mem[i];
			out_pos      = '0;
			first_taken  = '0;
			second_taken = '0;
			r.pass_end   = 1'b1;
			passes_done  = passes_done + 8'd1;
			if (passes_done >= pass_limit) begin
				r.shuffle_end = 1'b1;
				passes_done   = '0;
			end
		end
		picks_due.push_back(r);
	endtask

	task automatic check_result(input rse_pkg::rse_out_t got);
		rse_pkg::rse_out_t want;
		results_seen++;
		if (picks_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with no pick outstanding",
				results_seen));
		end else begin
			want = picks_due.pop_front();
			if (got.picked_value !== want.picked_value)
				report_mismatch($sformatf("result %0d picked_value %h, want %h",
					results_seen, got.picked_value, want.picked_value));
			if (got.pass_end !== want.pass_end)
				report_mismatch($sformatf("result %0d pass_end %b, want %b",
					results_seen, got.pass_end, want.pass_end));
			if (got.shuffle_end !== want.shuffle_end)
				report_mismatch($sformatf("result %0d shuffle_end %b, want %b",
					results_seen, got.shuffle_end, want.shuffle_end));
		end
	endtask

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_count = '0;
			load_pos   = '0;
			clear_pass();
			pass_limit = rse_pkg::PASS_COUNT_RST;
			picks_due.delete();
			pending      = 0;
			fail_count   = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				pass_limit = cfg_data;
			if (req_valid && !req_stall) begin
				if (req.cmd == rse_pkg::CMD_LOAD)
					store_element(req.element_value, req.load_last);
				else if (elem_count != 0)
					riffle_pick(req.coin);
			end
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			pending = picks_due.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_ITEMS = 800;
	localparam int DEPTH        = rse_pkg::MAX_ELEMENTS_DEF;

	typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
	typedef enum int {COIN_LOW, COIN_HIGH, COIN_RANDOM} coin_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	rse_pkg::rse_in_t  req;
	logic              rsp_valid;
	logic              rsp_stall;
	rse_pkg::rse_out_t rsp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [7:0]        cfg_data;

	int fail_count;
	int pending;
	int results_seen;

	// sender bookkeeping and a shadow of length and pass position
	int          burst_left = 0;
	int          loads_sent = 0;
	int          picks_sent = 0;
	int          cfg_writes = 0;
	int          sh_count   = 0;
	int          sh_out     = 0;
	int          sh_loadpos = 0;
	bit          seq_open   = 1'b0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always #5 clk = ~clk;

	riffle_shuffle_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	rse_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// receiver back-pressure, switching between patterns
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(8, 80);
		end
		stall_left = stall_left - 1;
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default:     rsp_stall <= stall_left[2];
		endcase
	end

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic next_coin(input coin_mode_t m);
		case (m)
			COIN_LOW:  return 1'b0;
			COIN_HIGH: return 1'b1;
			default:   return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic logic [7:0] pick_pass_count();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd2;
			3:       return 8'd3;
			4:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one request, sent in bursts with random gaps
	task automatic send_req(input rse_pkg::rse_in_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_load(input logic [31:0] value, input logic last);
		rse_pkg::rse_in_t it;
		it.cmd           = rse_pkg::CMD_LOAD;
		it.element_value = value;
		it.load_last     = last;
		it.coin          = 1'($urandom_range(0, 1));
		send_req(it);
		loads_sent++;
		if (sh_loadpos < DEPTH)
			sh_loadpos++;
		if (last) begin
			sh_count   = sh_loadpos;
			sh_loadpos = 0;
			sh_out     = 0;
			seq_open   = 1'b0;
		end else begin
			seq_open = 1'b1;
		end
	endtask

	task automatic send_pick(input logic coin);
		rse_pkg::rse_in_t it;
		it.cmd           = rse_pkg::CMD_PICK;
		it.element_value = $urandom;
		it.load_last     = 1'($urandom_range(0, 1));
		it.coin          = coin;
		send_req(it);
		picks_sent++;
		if (sh_count != 0) begin
			sh_out++;
			if (sh_out >= sh_count)
				sh_out = 0;
		end
	endtask

	// drop valid, let outstanding picks and the pipeline drain
	task automatic wait_idle();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_pass_count(input logic [7:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// run limit
	initial begin
		#(5_000_000);
		$display("timeout with %0d picks outstanding", pending);
		$display("** riffle_shuffle_engine: FAILED **");
		$finish;
	end

	initial begin
		int         len;
		int         npicks;
		int         r;
		int         base;
		coin_mode_t cmode;

		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// picks before any array is loaded give nothing
		send_pick(1'b0);
		send_pick(1'b1);

		// length one: every pick ends a pass and the shuffle
		send_load(32'h8000_0000, 1'b1);
		send_pick(1'b0);
		send_pick(1'b1);

		// odd length with extremes, one pass each coin
		send_load(32'h7fff_ffff, 1'b0);
		send_load(32'h0000_0000, 1'b0);
		send_load(32'hffff_ffff, 1'b0);
		send_load(32'h0000_0001, 1'b0);
		send_load(32'h5555_5555, 1'b1);
		repeat (5) send_pick(1'b0);
		repeat (5) send_pick(1'b1);

		// random phases of well-formed arrays with broken loads mixed in
		base = loads_sent + picks_sent;
		while (loads_sent + picks_sent - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				write_pass_count(pick_pass_count());
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			for (int i = 0; i < len; i++)
				send_load(rand_elem(), i == len - 1);
			cmode  = coin_mode_t'($urandom_range(0, 3) == 3 ? COIN_RANDOM : $urandom_range(0, 2));
			npicks = $urandom_range(1, 3 * len + 2);
			for (int k = 0; k < npicks; k++) begin
				r = $urandom_range(0, 99);
				// a fresh load may start mid-pass, but no pass may end before its last mark
				if (r < 4)
					send_load(rand_elem(), 1'b0);
				else if (seq_open && (r < 12 || sh_out + 1 >= sh_count))
					send_load(rand_elem(), 1'b1);
				else
					send_pick(next_coin(cmode));
			end
			if (seq_open)
				send_load(rand_elem(), 1'b1);
		end

		// full 255 pass shuffle on one element, then a new shuffle begins
		write_pass_count(8'd255);
		send_load(rand_elem(), 1'b1);
		repeat (257) send_pick(1'($urandom_range(0, 1)));

		wait_idle();
		$display("covered %0d loads, %0d picks and %0d pass count writes",
			loads_sent, picks_sent, cfg_writes);
		$display("%0d results compared, lengths from one to 64", results_seen);
		if (fail_count == 0 && pending == 0)
			$display("** riffle_shuffle_engine: PASSED **");
		else
			$display("** riffle_shuffle_engine: FAILED **");
		$finish;
	end

endmodule
